// File: design/urb_pkg.sv
// Shared types and codes for the UART ring buffer controller.
package urb_pkg;

  localparam int BYTE_W  = 8;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int LEVEL_W = 4;

  localparam logic [OP_W-1:0] OP_RX_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_TX_DONE = 2'd1;
  localparam logic [OP_W-1:0] OP_CPU_WR  = 2'd2;
  localparam logic [OP_W-1:0] OP_CPU_RD  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_RX_DROP  = 2'd1;
  localparam logic [STAT_W-1:0] ST_TX_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RX_EMPTY = 2'd3;

  typedef struct packed {
    logic push;
    logic pop;
  } urb_fifo_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } urb_fifo_stat_t;

endpackage

// File: design/urb_cell.sv
// One byte cell of a shifting queue chain.
module urb_cell (
  input  logic                       clk,
  input  logic                       load,
  input  logic                       shift,
  input  logic [urb_pkg::BYTE_W-1:0] din,
  input  logic [urb_pkg::BYTE_W-1:0] next_data,
  output logic [urb_pkg::BYTE_W-1:0] data
);
  import urb_pkg::*;

  logic [BYTE_W-1:0] data_r;
  logic [BYTE_W-1:0] data_nxt;

  // Loads and shifts never coincide since one operation is either a push or a pop.
  always_comb begin
    priority if (load) begin
      data_nxt = din;
    end else if (shift) begin
      data_nxt = next_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// File: design/urb_fifo_chain.sv
// Byte queue built as a row of shifting cells with an occupancy count.
module urb_fifo_chain #(
  parameter int DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  urb_pkg::urb_fifo_ctl_t      ctl,
  input  logic [urb_pkg::BYTE_W-1:0]  din,
  output urb_pkg::urb_fifo_stat_t     stat,
  output logic [urb_pkg::BYTE_W-1:0]  head_data,
  output logic [urb_pkg::LEVEL_W-1:0] level_nxt
);
  import urb_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic [BYTE_W-1:0]     cell_data [DEPTH];
  logic [CW+LEVEL_W-1:0] count_ext;

  // The oldest byte always sits in cell zero; a pop moves every byte one cell forward.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [BYTE_W-1:0] nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = cell_data[i];
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end
    urb_cell u_cell (
      .clk       (clk),
      .load      (ctl.push && (count_r == CW'(i))),
      .shift     (ctl.pop),
      .din       (din),
      .next_data (nbr),
      .data      (cell_data[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_data  = cell_data[0];
  assign count_ext  = {{LEVEL_W{1'b0}}, count_nxt};
  assign level_nxt  = count_ext[LEVEL_W-1:0];

  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && ctl.pop)) else $error("queue push and pop in one cycle");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !stat.full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> !stat.empty) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count beyond depth");

endmodule

// File: design/uart_ring_buffer_controller.sv
// Top level of the UART ring buffer controller with receive and transmit queues.
//
// Usage: each input transaction carries one operation (in_op) and a byte
// (in_data_in). Operation 0 stores a byte received from the line, 1 reports
// that the transmitter finished a byte, 2 is a CPU write and 3 a CPU read.
// Every input transaction produces exactly one output transaction that says
// whether a byte goes to the transmit shift register (out_tx_start,
// out_tx_byte), which byte the CPU read (out_read_byte), a status code and
// the queue levels and busy flag after the operation.
// The result is registered: it is in the output register on the cycle
// after acceptance. Throughput is one operation per cycle while out_ready
// stays high, set by the single push or pop a queue's cell row performs per cycle.
// Reset empties both queues and clears the busy flag; the queue cells keep
// stale data, which is never read because the counts guard every pop.
// When the receiver stalls (out_ready low) the result is held and
// in_ready drops until the result has been taken.
module uart_ring_buffer_controller #(
  parameter int RX_DEPTH = 8,
  parameter int TX_DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [urb_pkg::OP_W-1:0]    in_op,
  input  logic [urb_pkg::BYTE_W-1:0]  in_data_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_tx_start,
  output logic [urb_pkg::BYTE_W-1:0]  out_tx_byte,
  output logic [urb_pkg::BYTE_W-1:0]  out_read_byte,
  output logic [urb_pkg::STAT_W-1:0]  out_status,
  output logic [urb_pkg::LEVEL_W-1:0] out_rx_level,
  output logic [urb_pkg::LEVEL_W-1:0] out_tx_level,
  output logic                        out_tx_busy
);
  import urb_pkg::*;

  logic              fire;
  logic              busy_r;
  logic              busy_nxt;
  urb_fifo_ctl_t     rx_ctl;
  urb_fifo_ctl_t     tx_ctl;
  urb_fifo_stat_t    rx_stat;
  urb_fifo_stat_t    tx_stat;
  logic [BYTE_W-1:0] rx_head;
  logic [BYTE_W-1:0] tx_head;
  logic [LEVEL_W-1:0] rx_level_nxt;
  logic [LEVEL_W-1:0] tx_level_nxt;

  logic              start_nxt;
  logic [BYTE_W-1:0] sent_nxt;
  logic [BYTE_W-1:0] popped_nxt;
  logic [STAT_W-1:0] status_nxt;

  logic               out_valid_r;
  logic               tx_start_r;
  logic [BYTE_W-1:0]  tx_byte_r;
  logic [BYTE_W-1:0]  read_byte_r;
  logic [STAT_W-1:0]  status_r;
  logic [LEVEL_W-1:0] rx_level_r;
  logic [LEVEL_W-1:0] tx_level_r;
  logic               tx_busy_r;

  // A new transaction is taken whenever the output register is empty or
  // being drained in the same cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  // Operation decode. Full queues and an empty receive queue report a status
  // and leave the queues untouched instead of waiting.
  always_comb begin
    rx_ctl     = '0;
    tx_ctl     = '0;
    busy_nxt   = busy_r;
    start_nxt  = 1'b0;
    sent_nxt   = '0;
    popped_nxt = '0;
    status_nxt = ST_OK;
    if (fire) begin
      unique case (in_op)
        OP_RX_BYTE: begin
          if (rx_stat.full) begin
            status_nxt = ST_RX_DROP;
          end else begin
            rx_ctl.push = 1'b1;
          end
        end
        OP_TX_DONE: begin
          if (tx_stat.empty) begin
            busy_nxt = 1'b0;
          end else begin
            tx_ctl.pop = 1'b1;
            busy_nxt   = 1'b1;
            start_nxt  = 1'b1;
            sent_nxt   = tx_head;
          end
        end
        OP_CPU_WR: begin
          if (tx_stat.full) begin
            status_nxt = ST_TX_FULL;
          end else if (busy_r) begin
            tx_ctl.push = 1'b1;
          end else begin
            start_nxt = 1'b1;
            sent_nxt  = in_data_in;
            busy_nxt  = 1'b1;
          end
        end
        OP_CPU_RD: begin
          if (rx_stat.empty) begin
            status_nxt = ST_RX_EMPTY;
          end else begin
            rx_ctl.pop = 1'b1;
            popped_nxt = rx_head;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  urb_fifo_chain #(.DEPTH(RX_DEPTH)) u_rx_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rx_ctl),
    .din       (in_data_in),
    .stat      (rx_stat),
    .head_data (rx_head),
    .level_nxt (rx_level_nxt)
  );

  urb_fifo_chain #(.DEPTH(TX_DEPTH)) u_tx_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (tx_ctl),
    .din       (in_data_in),
    .stat      (tx_stat),
    .head_data (tx_head),
    .level_nxt (tx_level_nxt)
  );

  // Control state: busy flag and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, loaded only when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (fire) begin
      tx_start_r  <= start_nxt;
      tx_byte_r   <= sent_nxt;
      read_byte_r <= popped_nxt;
      status_r    <= status_nxt;
      rx_level_r  <= rx_level_nxt;
      tx_level_r  <= tx_level_nxt;
      tx_busy_r   <= busy_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tx_start  = tx_start_r;
  assign out_tx_byte   = tx_byte_r;
  assign out_read_byte = read_byte_r;
  assign out_status    = status_r;
  assign out_rx_level  = rx_level_r;
  assign out_tx_level  = tx_level_r;
  assign out_tx_busy   = tx_busy_r;

  // A started byte always leaves the transmitter marked busy.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && tx_start_r |-> tx_busy_r) else $error("tx start without busy");
  // An error status never comes with a started or popped byte.
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ST_OK) |-> !tx_start_r && (read_byte_r == '0))
    else $error("error status with side effect");
  // Queued transmit bytes imply the transmitter is busy.
  a_queue_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !tx_stat.empty |-> busy_r) else $error("tx queue holds bytes while idle");
  // The queues and the busy flag change only when a transaction is accepted.
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |-> (rx_ctl == '0) && (tx_ctl == '0) && (busy_nxt == busy_r))
    else $error("state change without transaction");

endmodule

// File: dv/urb_result_checker.sv
// Result checker for the UART ring buffer controller: predicts every result and compares it.
module urb_result_checker #(
  parameter int RX_DEPTH = 8,
  parameter int TX_DEPTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [urb_pkg::OP_W-1:0]    in_op,
  input  logic [urb_pkg::BYTE_W-1:0]  in_data_in,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        out_tx_start,
  input  logic [urb_pkg::BYTE_W-1:0]  out_tx_byte,
  input  logic [urb_pkg::BYTE_W-1:0]  out_read_byte,
  input  logic [urb_pkg::STAT_W-1:0]  out_status,
  input  logic [urb_pkg::LEVEL_W-1:0] out_rx_level,
  input  logic [urb_pkg::LEVEL_W-1:0] out_tx_level,
  input  logic                        out_tx_busy,
  output int                          mismatch_count,
  output int                          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;
  import urb_pkg::*;

  typedef struct {
    logic               tx_start;
    logic [BYTE_W-1:0]  tx_byte;
    logic [BYTE_W-1:0]  read_byte;
    logic [STAT_W-1:0]  status;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
    logic               tx_busy;
  } uart_result_t;

  // Shadow copy of the two queues and the transmitter flag.
  logic [BYTE_W-1:0] rx_mem [RX_DEPTH];
  logic [BYTE_W-1:0] tx_mem [TX_DEPTH];
  int                rx_fill;
  int                tx_fill;
  int                rx_first;
  int                tx_first;
  logic              tx_active;

  uart_result_t expected_results [$];
  int           error_total = 0;
  int           results_seen = 0;
  int           pending_q = 0;

  assign mismatch_count  = error_total;
  assign pending_results = pending_q;

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_total++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_error($sformatf("transaction %0d: %s got 0x%0h, expected 0x%0h",
                             results_seen, name, got, want));
  endtask

  function automatic uart_result_t uart_queue_step(input logic [OP_W-1:0]   op,
                                                   input logic [BYTE_W-1:0] data);
    uart_result_t r;
    r = '{default: '0};
    case (op)
      OP_RX_BYTE: begin
        if (rx_fill < RX_DEPTH) begin
          rx_mem[(rx_first + rx_fill) % RX_DEPTH] = data;
          rx_fill++;
        end else begin
          r.status = ST_RX_DROP;
        end
      end
      OP_TX_DONE: begin
        if (tx_fill != 0) begin
          tx_active  = 1'b1;
          tx_fill--;
          r.tx_start = 1'b1;
          r.tx_byte  = tx_mem[tx_first];
          tx_first   = (tx_first + 1) % TX_DEPTH;
        end else begin
          tx_active = 1'b0;
        end
      end
      OP_CPU_WR: begin
        if (tx_fill >= TX_DEPTH) begin
          r.status = ST_TX_FULL;
        end else if (tx_active) begin
          tx_mem[(tx_first + tx_fill) % TX_DEPTH] = data;
          tx_fill++;
        end else begin
          r.tx_start = 1'b1;
          r.tx_byte  = data;
          tx_active  = 1'b1;
        end
      end
      OP_CPU_RD: begin
        if (rx_fill == 0) begin
          r.status = ST_RX_EMPTY;
        end else begin
          rx_fill--;
          r.read_byte = rx_mem[rx_first];
          rx_first    = (rx_first + 1) % RX_DEPTH;
        end
      end
      default: ;
    endcase
    r.rx_level = LEVEL_W'(rx_fill);
    r.tx_level = LEVEL_W'(tx_fill);
    r.tx_busy  = tx_active;
    return r;
  endfunction

  always @(posedge clk) begin : watch_channels
    uart_result_t want;
    if (!rst_n) begin
      rx_fill   = 0;
      tx_fill   = 0;
      rx_first  = 0;
      tx_first  = 0;
      tx_active = 1'b0;
      expected_results.delete();
    end else begin
      // The result of an item never leaves in the cycle it is accepted, so
      // the output side is handled before the new prediction is queued.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_error("result transaction arrived with none expected");
        end else begin
          want = expected_results.pop_front();
          check_field("tx_start", out_tx_start, want.tx_start);
          check_field("tx_byte", out_tx_byte, want.tx_byte);
          check_field("read_byte", out_read_byte, want.read_byte);
          check_field("status", out_status, want.status);
          check_field("rx_level", out_rx_level, want.rx_level);
          check_field("tx_level", out_tx_level, want.tx_level);
          check_field("tx_busy", out_tx_busy, want.tx_busy);
        end
        results_seen++;
      end
      if (in_valid && in_ready)
        expected_results.push_back(uart_queue_step(in_op, in_data_in));
    end
    pending_q <= expected_results.size();
  end

endmodule

// File: dv/tb_uart_ring_buffer_controller.sv
// Top of the UART ring buffer controller testbench: clock, reset, stimulus and verdict.
module tb_uart_ring_buffer_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import urb_pkg::*;

  localparam int RX_DEPTH        = 8;
  localparam int TX_DEPTH        = 8;
  // Random items on top of the short directed opening; together about 650.
  localparam int RANDOM_ITEMS    = 628;
  // The receiver holds off once for this long while the sender keeps going.
  localparam int HOLD_OFF_CYCLES = 64;
  // No correct run goes this long without a transaction on either channel:
  // the longest wait is the hold-off above plus one random stall.
  localparam int STALL_LIMIT     = 2000;

  // Operation mixes for the random bursts. All but MIX_OPS lean on a single
  // operation so that the queues really reach full and empty.
  typedef enum int {MIX_OPS, FILL_RX, DRAIN_RX, FILL_TX, DRAIN_TX} op_mix_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_op = OP_RX_BYTE;
  logic [BYTE_W-1:0]   in_data_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_tx_start;
  logic [BYTE_W-1:0]   out_tx_byte;
  logic [BYTE_W-1:0]   out_read_byte;
  logic [STAT_W-1:0]   out_status;
  logic [LEVEL_W-1:0]  out_rx_level;
  logic [LEVEL_W-1:0]  out_tx_level;
  logic                out_tx_busy;

  int mismatch_count;
  int pending_results;
  int idle_cycles = 0;

  // Shared between the two sides: when no_idle is set neither side inserts
  // gaps, and hold_request asks the receiver for one long hold-off.
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  uart_ring_buffer_controller #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_tx_start (out_tx_start),
    .out_tx_byte  (out_tx_byte),
    .out_read_byte(out_read_byte),
    .out_status   (out_status),
    .out_rx_level (out_rx_level),
    .out_tx_level (out_tx_level),
    .out_tx_busy  (out_tx_busy)
  );

  urb_result_checker #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) result_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_tx_start   (out_tx_start),
    .out_tx_byte    (out_tx_byte),
    .out_read_byte  (out_read_byte),
    .out_status     (out_status),
    .out_rx_level   (out_rx_level),
    .out_tx_level   (out_tx_level),
    .out_tx_busy    (out_tx_busy),
    .mismatch_count (mismatch_count),
    .pending_results(pending_results)
  );

  // Offers one operation on the input channel and returns right after the
  // rising edge at which it was accepted. A random gap with valid low comes
  // first; with no gap the next transaction follows back to back and valid
  // simply stays high while the payload changes.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_op      <= op;
    in_data_in <= data;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid and waits until every predicted result has been taken.
  // The count is read at the falling edge, after the checker has updated it.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  function automatic logic [OP_W-1:0] pick_op(input op_mix_t mix);
    logic [OP_W-1:0] every_op [4];
    logic [OP_W-1:0] favored;
    every_op = '{OP_RX_BYTE, OP_TX_DONE, OP_CPU_WR, OP_CPU_RD};
    case (mix)
      FILL_RX:  favored = OP_RX_BYTE;
      DRAIN_RX: favored = OP_CPU_RD;
      FILL_TX:  favored = OP_CPU_WR;
      DRAIN_TX: favored = OP_TX_DONE;
      default:  favored = every_op[$urandom_range(0, 3)];
    endcase
    // A favored mix still lets other operations through now and then, so
    // the queues fill in an interleaved way rather than strictly in order.
    if (mix == MIX_OPS || $urandom_range(0, 99) < 70)
      return favored;
    return every_op[$urandom_range(0, 3)];
  endfunction

  // Receiver side. Before each result it draws a stall with ready low; a
  // pending hold-off request replaces that stall with one long stretch, so
  // that the output register stays full and the block stops taking input.
  initial begin : result_sink
    int stall;
    wait (rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 11);
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: any run that goes quiet on both channels for too long has lost
  // a transaction somewhere, either an input never accepted or a result
  // that never came.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    op_mix_t mix;
    int      burst;
    int      sent_random;
    sent_random = 0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening. Both queues start empty, so the first read finds
    // nothing and a transmit-done arrives while the transmitter is idle.
    send_item(OP_CPU_RD, 8'hA5);
    send_item(OP_TX_DONE, 8'h5A);
    // A write to an idle transmitter starts at once; the next eight writes
    // find it busy and fill the transmit queue, and one more is refused.
    send_item(OP_CPU_WR, 8'h00);
    send_item(OP_CPU_WR, 8'hFF);
    send_item(OP_CPU_WR, 8'h55);
    send_item(OP_CPU_WR, 8'hAA);
    send_item(OP_CPU_WR, 8'h01);
    send_item(OP_CPU_WR, 8'h80);
    send_item(OP_CPU_WR, 8'h7F);
    send_item(OP_CPU_WR, 8'hFE);
    send_item(OP_CPU_WR, 8'h3C);
    send_item(OP_CPU_WR, 8'hC3);
    // A transmit-done with bytes queued hands the oldest one out.
    send_item(OP_TX_DONE, 8'h00);
    // Fill the receive buffer, then one more byte is dropped.
    send_item(OP_RX_BYTE, 8'hFF);
    send_item(OP_RX_BYTE, 8'h00);
    send_item(OP_RX_BYTE, 8'hAA);
    send_item(OP_RX_BYTE, 8'h55);
    send_item(OP_RX_BYTE, 8'h0F);
    send_item(OP_RX_BYTE, 8'hF0);
    send_item(OP_RX_BYTE, 8'h81);
    send_item(OP_RX_BYTE, 8'h7E);
    send_item(OP_RX_BYTE, 8'h99);
    send_item(OP_CPU_RD, 8'hFF);

    // Random bursts, each with its own operation mix. About one burst in
    // five runs with no idling on either side.
    while (sent_random < RANDOM_ITEMS) begin
      mix     = op_mix_t'($urandom_range(0, 4));
      no_idle = ($urandom_range(0, 4) == 0);
      burst   = $urandom_range(8, 40);
      repeat (burst) begin
        send_item(pick_op(mix), BYTE_W'($urandom_range(0, 255)));
        sent_random++;
        // Long receiver hold-off while the sender keeps offering.
        if (sent_random == 200)
          hold_request = 1'b1;
        // The sender pauses until every expected result is back.
        if (sent_random == 420)
          wait_for_results();
      end
    end

    wait_for_results();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: uart_ring_buffer_controller.f
design/urb_pkg.sv
design/urb_cell.sv
design/urb_fifo_chain.sv
design/uart_ring_buffer_controller.sv
dv/urb_result_checker.sv
dv/tb_uart_ring_buffer_controller.sv
